// ===== rtl/core/crcrd_pkg.sv =====
package crcrd_pkg;

  localparam int BODY_BYTES = 22;
  localparam int POS_W = $clog2(BODY_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(BODY_BYTES - 1);

  localparam int GEN_OFS = 0;
  localparam int GEN_LEN = 4;
  localparam int SEQ_OFS = 4;
  localparam int SEQ_LEN = 4;
  localparam int TIME_OFS = 8;
  localparam int TIME_LEN = 8;
  localparam int UNC_OFS = 16;
  localparam int UNC_LEN = 4;
  localparam int FLAG_OFS = 20;
  localparam int FLAG_LEN = 2;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLAG_MASK = 2'd2;

  localparam logic [15:0] CRC_INIT_RST = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_RST = 16'h1021;
  localparam logic [15:0] FLAG_MASK_RST = 16'hFFFF;

  typedef struct packed {
    logic [15:0] crc_init;
    logic [15:0] crc_poly;
    logic [15:0] flag_mask;
  } cfg_t;

  typedef struct packed {
    logic [31:0] generation_number;
    logic [31:0] sequence_number;
    logic [63:0] event_time;
    logic [31:0] uncertainty;
    logic [15:0] flag_bits;
    logic [15:0] computed_crc;
    logic        crc_ok;
    logic        record_ok;
  } record_t;

endpackage

// ===== rtl/core/crcrd_front.sv =====
module crcrd_front
  import crcrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [15:0] in_rx_crc,
  output record_t     rec,
  input  logic        q_full,
  output logic        q_push
);

  logic [POS_W-1:0] pos_r;
  logic [15:0]      crc_r;
  logic [15:0]      crc_nxt;
  logic [7:0]       body_r [BODY_BYTES];
  logic [7:0]       bytes_all [BODY_BYTES];
  logic             is_last;
  logic             accept;

  always_comb begin
    crc_nxt = ((pos_r == '0) ? cfg.crc_init : crc_r) ^ {in_data_byte, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc_nxt[15]) begin
        crc_nxt = {crc_nxt[14:0], 1'b0} ^ cfg.crc_poly;
      end else begin
        crc_nxt = {crc_nxt[14:0], 1'b0};
      end
    end
  end

  assign is_last  = (pos_r == LAST_POS);
  assign in_stall = is_last & q_full;
  assign accept   = in_valid & ~in_stall;
  assign q_push   = accept & is_last;

  always_comb begin
    for (int i = 0; i < BODY_BYTES - 1; i++) begin
      bytes_all[i] = body_r[i];
    end
    bytes_all[BODY_BYTES-1] = in_data_byte;
  end

  always_comb begin
    rec = '0;
    for (int i = 0; i < GEN_LEN; i++) begin
      rec.generation_number[8*i +: 8] = bytes_all[GEN_OFS+i];
    end
    for (int i = 0; i < SEQ_LEN; i++) begin
      rec.sequence_number[8*i +: 8] = bytes_all[SEQ_OFS+i];
    end
    for (int i = 0; i < TIME_LEN; i++) begin
      rec.event_time[8*i +: 8] = bytes_all[TIME_OFS+i];
    end
    for (int i = 0; i < UNC_LEN; i++) begin
      rec.uncertainty[8*i +: 8] = bytes_all[UNC_OFS+i];
    end
    for (int i = 0; i < FLAG_LEN; i++) begin
      rec.flag_bits[8*i +: 8] = bytes_all[FLAG_OFS+i];
    end
    rec.computed_crc = crc_nxt;
    rec.crc_ok       = (crc_nxt == in_rx_crc);
    rec.record_ok    = (rec.generation_number != '0) && (rec.uncertainty != '0) &&
                       ((rec.flag_bits & ~cfg.flag_mask) == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= is_last ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      crc_r         <= crc_nxt;
      body_r[pos_r] <= in_data_byte;
    end
  end

endmodule

// ===== rtl/core/crcrd_queue.sv =====
module crcrd_queue
  import crcrd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  record_t wr_rec,
  output logic    full,
  input  logic    pop,
  output record_t rd_rec,
  output logic    empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  record_t          mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_rec  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_rec;
    end
  end

endmodule

// ===== rtl/core/crcrd_back.sv =====
module crcrd_back
  import crcrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  record_t     rec,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_generation_number,
  output logic [31:0] out_sequence_number,
  output logic [63:0] out_event_time,
  output logic [31:0] out_uncertainty,
  output logic [15:0] out_flag_bits,
  output logic [15:0] out_computed_crc,
  output logic        out_crc_ok,
  output logic        out_record_ok
);

  logic        valid_r;
  record_t     rec_r;
  logic        load;

  assign load  = ~q_empty & (~valid_r | ~out_stall);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_r <= rec;
    end
  end

  assign out_valid             = valid_r;
  assign out_generation_number = rec_r.generation_number;
  assign out_sequence_number   = rec_r.sequence_number;
  assign out_event_time        = rec_r.event_time;
  assign out_uncertainty       = rec_r.uncertainty;
  assign out_flag_bits         = rec_r.flag_bits;
  assign out_computed_crc      = rec_r.computed_crc;
  assign out_crc_ok            = rec_r.crc_ok;
  assign out_record_ok         = rec_r.record_ok;

endmodule

// ===== rtl/core/crc_checked_record_deserializer_top.sv =====
// Deserializes 22-byte record bodies that arrive one byte per input word and
// checks each one with a CRC-16 that runs MSB first with no final xor.
// The input channel carries a body byte and the received CRC, which is only
// sampled with the last byte of a record. Body bytes can be taken back to back,
// so a record needs 22 input words and a new record can follow without a gap.
// When the last byte is taken, the record enters a two-entry queue; from there the
// decoded fields, CRC and check flags move into the output register and appear on
// the output channel, one word per record.
// The configuration channel writes the CRC start value, the polynomial and the
// allowed flag mask; it is always ready. A new start value is used from the next
// record start onward.
// Reset returns the byte counter to the first byte, empties the queue, clears
// the output valid and restores the register defaults.
// When the receiver stalls, the output word holds, the queue fills, and only the
// last byte of a record is then stalled until a queue entry frees up.
module crc_checked_record_deserializer_top
  import crcrd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic [15:0]          in_rx_crc,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_generation_number,
  output logic [31:0]          out_sequence_number,
  output logic [63:0]          out_event_time,
  output logic [31:0]          out_uncertainty,
  output logic [15:0]          out_flag_bits,
  output logic [15:0]          out_computed_crc,
  output logic                 out_crc_ok,
  output logic                 out_record_ok,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_t    cfg_r;
  record_t front_rec;
  record_t head_rec;
  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.crc_init  <= CRC_INIT_RST;
      cfg_r.crc_poly  <= CRC_POLY_RST;
      cfg_r.flag_mask <= FLAG_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CRC_INIT:  cfg_r.crc_init  <= cfg_data;
        REG_CRC_POLY:  cfg_r.crc_poly  <= cfg_data;
        REG_FLAG_MASK: cfg_r.flag_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  crcrd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_rx_crc    (in_rx_crc),
    .rec          (front_rec),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  crcrd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (front_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (head_rec),
    .empty  (q_empty)
  );

  crcrd_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .rec                   (head_rec),
    .q_empty               (q_empty),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_generation_number (out_generation_number),
    .out_sequence_number   (out_sequence_number),
    .out_event_time        (out_event_time),
    .out_uncertainty       (out_uncertainty),
    .out_flag_bits         (out_flag_bits),
    .out_computed_crc      (out_computed_crc),
    .out_crc_ok            (out_crc_ok),
    .out_record_ok         (out_record_ok)
  );

endmodule

// ===== tb/sv/crcrd_record_checker.sv =====
module crcrd_record_checker
  import crcrd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic [15:0]          in_rx_crc,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [31:0]          out_generation_number,
  input  logic [31:0]          out_sequence_number,
  input  logic [63:0]          out_event_time,
  input  logic [31:0]          out_uncertainty,
  input  logic [15:0]          out_flag_bits,
  input  logic [15:0]          out_computed_crc,
  input  logic                 out_crc_ok,
  input  logic                 out_record_ok,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   fail_count,
  output int                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] generation_number;
    logic [31:0] sequence_number;
    logic [63:0] event_time;
    logic [31:0] uncertainty;
    logic [15:0] flag_bits;
    logic [15:0] computed_crc;
    logic        crc_ok;
    logic        record_ok;
  } record_fields_t;

  logic [15:0]    init_reg;
  logic [15:0]    poly_reg;
  logic [15:0]    mask_reg;
  logic [15:0]    crc_run;
  int             byte_idx;
  logic [7:0]     body [BODY_BYTES];
  record_fields_t pending_records [$];

  function automatic logic [15:0] crc_advance(logic [15:0] crc, logic [7:0] b,
                                              logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [63:0] le_field(int ofs, int len);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < len; i++) begin
      v[8*i +: 8] = body[ofs + i];
    end
    return v;
  endfunction

  task automatic report(string field, logic [63:0] want, logic [63:0] got);
    if (fail_count < 10) begin
      $display("mismatch in %s: expected %h, got %h", field, want, got);
    end
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    record_fields_t fresh;
    record_fields_t want;
    logic [15:0]    seed;
    if (!rst_n) begin
      init_reg = CRC_INIT_RST;
      poly_reg = CRC_POLY_RST;
      mask_reg = FLAG_MASK_RST;
      crc_run = CRC_INIT_RST;
      byte_idx = 0;
      pending_records.delete();
    end else begin
      if (in_valid && !in_stall) begin
        seed = (byte_idx == 0) ? init_reg : crc_run;
        crc_run = crc_advance(seed, in_data_byte, poly_reg);
        body[byte_idx] = in_data_byte;
        byte_idx++;
        if (byte_idx == BODY_BYTES) begin
          fresh.generation_number = 32'(le_field(GEN_OFS, GEN_LEN));
          fresh.sequence_number = 32'(le_field(SEQ_OFS, SEQ_LEN));
          fresh.event_time = le_field(TIME_OFS, TIME_LEN);
          fresh.uncertainty = 32'(le_field(UNC_OFS, UNC_LEN));
          fresh.flag_bits = 16'(le_field(FLAG_OFS, FLAG_LEN));
          fresh.computed_crc = crc_run;
          fresh.crc_ok = (crc_run == in_rx_crc);
          fresh.record_ok = (fresh.generation_number != 0) && (fresh.uncertainty != 0) &&
                            ((fresh.flag_bits & ~mask_reg) == 16'h0000);
          pending_records.push_back(fresh);
          byte_idx = 0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CRC_INIT: init_reg = cfg_data;
          REG_CRC_POLY: poly_reg = cfg_data;
          REG_FLAG_MASK: mask_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_records.size() == 0) begin
          if (fail_count < 10) begin
            $display("result word with no record pending: generation %h",
                     out_generation_number);
          end
          fail_count++;
        end else begin
          want = pending_records.pop_front();
          if (out_generation_number !== want.generation_number)
            report("generation_number", want.generation_number, out_generation_number);
          if (out_sequence_number !== want.sequence_number)
            report("sequence_number", want.sequence_number, out_sequence_number);
          if (out_event_time !== want.event_time)
            report("event_time", want.event_time, out_event_time);
          if (out_uncertainty !== want.uncertainty)
            report("uncertainty", want.uncertainty, out_uncertainty);
          if (out_flag_bits !== want.flag_bits)
            report("flag_bits", want.flag_bits, out_flag_bits);
          if (out_computed_crc !== want.computed_crc)
            report("computed_crc", want.computed_crc, out_computed_crc);
          if (out_crc_ok !== want.crc_ok)
            report("crc_ok", want.crc_ok, out_crc_ok);
          if (out_record_ok !== want.record_ok)
            report("record_ok", want.record_ok, out_record_ok);
        end
      end
    end
    outstanding = pending_records.size();
  end

endmodule

// ===== tb/sv/crc_checked_record_deserializer_top_tb.sv =====
module crc_checked_record_deserializer_top_tb
  import crcrd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 500;
  localparam logic [8*BODY_BYTES-1:0] EDGE_BODY =
    176'hFFFF_FFFFFFFF_FF00AA55FE7F0180_FFFFFFFF_00000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_data_byte;
  logic [15:0]          in_rx_crc;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [31:0]          out_generation_number;
  logic [31:0]          out_sequence_number;
  logic [63:0]          out_event_time;
  logic [31:0]          out_uncertainty;
  logic [15:0]          out_flag_bits;
  logic [15:0]          out_computed_crc;
  logic                 out_crc_ok;
  logic                 out_record_ok;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  int          fail_count;
  int          outstanding;
  int          cycle_count = 0;
  int          stall_left = 0;
  int          calm_left = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  logic [15:0] cur_init = CRC_INIT_RST;
  logic [15:0] cur_poly = CRC_POLY_RST;
  logic [15:0] cur_mask = FLAG_MASK_RST;
  logic [15:0] tx_crc = CRC_INIT_RST;
  int          tx_pos = 0;

  crc_checked_record_deserializer_top DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_rx_crc             (in_rx_crc),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_generation_number (out_generation_number),
    .out_sequence_number   (out_sequence_number),
    .out_event_time        (out_event_time),
    .out_uncertainty       (out_uncertainty),
    .out_flag_bits         (out_flag_bits),
    .out_computed_crc      (out_computed_crc),
    .out_crc_ok            (out_crc_ok),
    .out_record_ok         (out_record_ok),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  crcrd_record_checker record_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_rx_crc             (in_rx_crc),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_generation_number (out_generation_number),
    .out_sequence_number   (out_sequence_number),
    .out_event_time        (out_event_time),
    .out_uncertainty       (out_uncertainty),
    .out_flag_bits         (out_flag_bits),
    .out_computed_crc      (out_computed_crc),
    .out_crc_ok            (out_crc_ok),
    .out_record_ok         (out_record_ok),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .fail_count            (fail_count),
    .outstanding           (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("crc_checked_record_deserializer_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES;
      calm_left = 0;
    end else if (stall_left == 0 && calm_left == 0) begin
      if (quiet || $urandom_range(0, 2) != 0) calm_left = $urandom_range(1, 24);
      else stall_left = $urandom_range(1, 11);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      calm_left--;
    end
  end

  function automatic logic [15:0] next_crc(logic [15:0] crc, logic [7:0] b,
                                           logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

  // With want_match set, the last byte of a record carries the CRC that the
  // block should compute, so that crc_ok comes out high.
  task automatic send_byte(input logic [7:0] b, input bit want_match);
    logic [15:0] nxt;
    logic [15:0] ec;
    nxt = next_crc((tx_pos == 0) ? cur_init : tx_crc, b, cur_poly);
    ec = 16'($urandom);
    if (tx_pos == BODY_BYTES - 1 && want_match) ec = nxt;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_rx_crc <= ec;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    tx_crc = nxt;
    tx_pos = (tx_pos + 1) % BODY_BYTES;
  endtask

  task automatic send_loose(input int count);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom), 1'($urandom));
    end
  endtask

  task automatic finish_partial();
    while (tx_pos != 0) send_byte(8'($urandom), 1'($urandom));
  endtask

  task automatic send_record();
    logic [7:0]  rec [BODY_BYTES];
    logic [15:0] fl;
    bit          match;
    for (int i = 0; i < BODY_BYTES; i++) rec[i] = 8'($urandom);
    case ($urandom_range(0, 5))
      0: for (int i = 0; i < GEN_LEN; i++) rec[GEN_OFS + i] = 8'h00;
      1: for (int i = 0; i < UNC_LEN; i++) rec[UNC_OFS + i] = 8'h00;
      default: ;
    endcase
    if ($urandom_range(0, 1) != 0) begin
      fl = 16'($urandom) & cur_mask;
      rec[FLAG_OFS] = fl[7:0];
      rec[FLAG_OFS + 1] = fl[15:8];
    end
    match = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < BODY_BYTES; i++) send_byte(rec[i], match);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Registers change only once the block has delivered every pending record.
  task automatic load_setup(input logic [15:0] init_v, input logic [15:0] poly_v,
                            input logic [15:0] mask_v);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (4) @(negedge clk);
    write_reg(REG_CRC_INIT, init_v);
    write_reg(REG_CRC_POLY, poly_v);
    write_reg(REG_FLAG_MASK, mask_v);
    cfg_valid <= 1'b0;
    cur_init = init_v;
    cur_poly = poly_v;
    cur_mask = mask_v;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_rx_crc = 16'h0000;
    cfg_valid = 1'b0;
    cfg_index = REG_CRC_INIT;
    cfg_data = 16'h0000;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < BODY_BYTES; i++) send_byte(EDGE_BODY[8*i +: 8], 1'b1);
    repeat (4) send_record();
    send_loose(9);

    // The polynomial changes in the middle of a record and the start value
    // waits for the next one.
    load_setup(16'h0000, 16'h8005, 16'h00FF);
    finish_partial();
    repeat (4) send_record();
    hold_req = 1'b1;
    repeat (4) send_record();
    send_loose(13);

    load_setup(16'hFFFF, 16'h0000, 16'h0000);
    finish_partial();
    repeat (5) send_record();

    load_setup(16'h0000, 16'hFFFF, 16'hFFFF);
    repeat (3) send_record();
    send_loose(4);

    repeat (3) begin
      load_setup(16'($urandom), 16'($urandom), 16'($urandom));
      finish_partial();
      repeat (3) send_record();
      send_loose($urandom_range(0, BODY_BYTES - 1));
    end

    quiet = 1'b1;
    load_setup(CRC_INIT_RST, CRC_POLY_RST, 16'($urandom));
    finish_partial();
    repeat (3) send_record();

    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (8) @(negedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("crc_checked_record_deserializer_top verification clean");
    end else begin
      $display("crc_checked_record_deserializer_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/crcrd_pkg.sv
rtl/core/crcrd_front.sv
rtl/core/crcrd_queue.sv
rtl/core/crcrd_back.sv
rtl/core/crc_checked_record_deserializer_top.sv
tb/sv/crcrd_record_checker.sv
tb/sv/crc_checked_record_deserializer_top_tb.sv
